// ===== hw/rtl/dsp_pkg.sv =====
//------------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants for the dual-stack processor core.
//------------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

  localparam int IMAGE_WORDS      = 8192;
  localparam int IMG_AW           = 13;
  localparam int PC_W             = 14;
  localparam int DATA_DEPTH_DEF   = 128;
  localparam int RETURN_DEPTH_DEF = 1024;
  localparam int PORT_COUNT_DEF   = 16;

  localparam int PORT_STATUS = 0;
  localparam int PORT_KEY    = 1;
  localparam int PORT_CHAR   = 2;
  localparam int PORT_SAVE   = 4;
  localparam int PORT_QUERY  = 5;

  localparam logic [31:0] QRY_IMAGE_SIZE = 32'hFFFF_FFFF;
  localparam logic [31:0] QRY_ZERO_A     = 32'hFFFF_FFFE;
  localparam logic [31:0] QRY_ZERO_B     = 32'hFFFF_FFFD;
  localparam logic [31:0] QRY_ZERO_C     = 32'hFFFF_FFFC;
  localparam logic [31:0] QRY_DATA_PTR   = 32'hFFFF_FFFB;
  localparam logic [31:0] QRY_RET_PTR    = 32'hFFFF_FFFA;

  typedef enum logic [2:0] {
    CMD_STEP    = 3'd0,
    CMD_IMG_WR  = 3'd1,
    CMD_IMG_RD  = 3'd2,
    CMD_PORT_WR = 3'd3,
    CMD_PORT_RD = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ILLEGAL = 2'd1,
    STAT_DIV0    = 2'd2,
    STAT_HALT    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LIT, OP_DUP, OP_DROP, OP_SWAP, OP_PUSH, OP_POP, OP_CALL,
    OP_JUMP, OP_RETURN, OP_GT_JUMP, OP_LT_JUMP, OP_NE_JUMP, OP_EQ_JUMP,
    OP_FETCH, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD, OP_AND, OP_OR,
    OP_XOR, OP_SHL, OP_SHR, OP_ZERO_EXIT, OP_INC, OP_DEC, OP_IN, OP_OUT,
    OP_WAIT
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_AND, ALU_OR, ALU_XOR, ALU_SHL, ALU_SHR
  } alu_op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CMD, S_RDW, S_DEC, S_EXEC, S_DIV
  } seq_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [IMG_AW-1:0] address;
    logic signed [31:0] data;
  } req_t;

  typedef struct packed {
    logic [PC_W-1:0]    pc;
    logic signed [31:0] top;
    logic signed [31:0] read_data;
    logic               char_valid;
    logic signed [31:0] char_out;
    logic               wait_request;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dsp_alu.sv =====
//------------------------------------------------------------------------------
// dsp_alu
// Shared arithmetic, logic, shift and compare unit.
//------------------------------------------------------------------------------
`default_nettype none

module dsp_alu (
  input  dsp_pkg::alu_op_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [31:0]      y,
  output logic             gt,
  output logic             lt,
  output logic             eq
);

  logic [63:0] prod;

  assign prod = a * b;
  assign gt   = $signed(a) > $signed(b);
  assign lt   = $signed(a) < $signed(b);
  assign eq   = a == b;

  always_comb begin
    unique case (op)
      dsp_pkg::ALU_ADD: y = a + b;
      dsp_pkg::ALU_SUB: y = a - b;
      dsp_pkg::ALU_MUL: y = prod[31:0];
      dsp_pkg::ALU_AND: y = a & b;
      dsp_pkg::ALU_OR:  y = a | b;
      dsp_pkg::ALU_XOR: y = a ^ b;
      dsp_pkg::ALU_SHL: y = a << b[4:0];
      dsp_pkg::ALU_SHR: y = $unsigned($signed(a) >>> b[4:0]);
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dsp_div.sv =====
//------------------------------------------------------------------------------
// dsp_div
// Signed restoring divider, one quotient bit per cycle, truncating.
//------------------------------------------------------------------------------
`default_nettype none

module dsp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic        run;
  logic [5:0]  cnt;
  logic [31:0] acc;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [31:0] a_mag;
  logic [31:0] b_mag;
  logic [32:0] trial;

  assign a_mag = a[31] ? (~a + 32'd1) : a;
  assign b_mag = b[31] ? (~b + 32'd1) : b;
  assign trial = {acc, quo[31]} - {1'b0, dvs};
  assign quot  = neg_q ? (~quo + 32'd1) : quo;
  assign rem   = neg_r ? (~acc + 32'd1) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd32;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      quo   <= a_mag;
      dvs   <= b_mag;
      neg_q <= a[31] ^ b[31];
      neg_r <= a[31];
    end else if (run) begin
      if (!trial[32]) begin
        acc <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        acc <= {acc[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_stack_processor_core.sv =====
//------------------------------------------------------------------------------
// dual_stack_processor_core
// Stack processor: sequencer, image/stack memories, ports, shared ALU, divider.
// Host commands finish in the command state; image reads add a read-wait state.
// A step runs fetch, operand/second-item read, execute, result;
// /MOD then waits on the bit-serial divider. One request at a time.
// After reset a clearing pass zeroes image and stacks;
// no request is accepted during it. Ports and pointers clear at once.
//------------------------------------------------------------------------------
`default_nettype none

module dual_stack_processor_core #(
  parameter int DATA_DEPTH   = dsp_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = dsp_pkg::RETURN_DEPTH_DEF,
  parameter int PORT_COUNT   = dsp_pkg::PORT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dsp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dsp_pkg::rsp_t rsp
);

  localparam int DW = $clog2(DATA_DEPTH);
  localparam int RW = $clog2(RETURN_DEPTH);
  localparam int PW = $clog2(PORT_COUNT);
  localparam int AW = dsp_pkg::IMG_AW;
  localparam int PCW = dsp_pkg::PC_W;

  function automatic logic [DW-1:0] dp_inc(input logic [DW-1:0] v);
    dp_inc = (v == DW'(DATA_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [DW-1:0] dp_dec(input logic [DW-1:0] v);
    dp_dec = (v == '0) ? DW'(DATA_DEPTH - 1) : v - 1'b1;
  endfunction

  function automatic logic [RW-1:0] rp_inc(input logic [RW-1:0] v);
    rp_inc = (v == RW'(RETURN_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [RW-1:0] rp_dec(input logic [RW-1:0] v);
    rp_dec = (v == '0) ? RW'(RETURN_DEPTH - 1) : v - 1'b1;
  endfunction

  dsp_pkg::seq_t state, state_next;
  logic [AW-1:0]  clr_cnt;
  dsp_pkg::cmd_t  cmd_r;
  logic [AW-1:0]  addr_r;
  logic [31:0]    data_r;

  logic [PCW-1:0] pc;
  logic [31:0]    top;
  logic [DW-1:0]  dp;
  logic [RW-1:0]  rp;
  logic [31:0]    op_r;
  logic [31:0]    n_r;
  logic [31:0]    r_r;
  logic           opnd_oob;

  logic [31:0] img_mem [dsp_pkg::IMAGE_WORDS];
  logic [31:0] ds_mem  [DATA_DEPTH];
  logic [31:0] rs_mem  [RETURN_DEPTH];
  logic [31:0] port_regs [PORT_COUNT];
  logic [31:0] img_q, ds_q, rs_q;

  logic          img_we;
  logic [AW-1:0] img_wa, img_ra;
  logic [31:0]   img_wd;
  logic          ds_we;
  logic [DW-1:0] ds_wa, ds_ra;
  logic [31:0]   ds_wd;
  logic          rs_we;
  logic [RW-1:0] rs_wa;
  logic [31:0]   rs_wd;

  logic [PW-1:0] port_rd_idx;
  logic [31:0]   port_rdata;
  logic          clearing;
  logic          halted;
  logic [31:0]   pc32;

  // execute stage results
  logic [31:0]      x_top, x_nx, x_co, x_ds_wd, x_rs_wd, x_pw_data, x_p5_val;
  logic [DW-1:0]    x_dp, x_ds_wa;
  logic [RW-1:0]    x_rp;
  dsp_pkg::status_t x_st;
  logic x_cv, x_wr, x_ds_we, x_rs_we, x_img_we, x_div_start;
  logic x_pw_we, x_p0_clr, x_p0_set, x_p2_clr, x_p4_clr, x_p5_we;
  logic [31:0]      opnd;
  logic             t_in_port;
  logic [PCW-1:0]   pc_fin;
  logic             exec_fire;

  dsp_pkg::alu_op_t alu_op;
  logic [31:0] alu_a, alu_b, alu_y;
  logic        alu_gt, alu_lt, alu_eq;

  logic        div_done;
  logic [31:0] div_quot, div_rem;

  logic          fin;
  dsp_pkg::rsp_t rsp_d;

  dsp_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .gt (alu_gt),
    .lt (alu_lt),
    .eq (alu_eq)
  );

  dsp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (x_div_start && state == dsp_pkg::S_EXEC),
    .a     (n_r),
    .b     (top),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign clearing    = state == dsp_pkg::S_CLEAR;
  assign halted      = pc >= PCW'(dsp_pkg::IMAGE_WORDS);
  assign pc32        = 32'(pc);
  assign opnd        = opnd_oob ? '0 : img_q;
  assign t_in_port   = top < 32'(PORT_COUNT);
  assign port_rd_idx = (state == dsp_pkg::S_CMD) ? addr_r[PW-1:0] : top[PW-1:0];
  assign port_rdata  = port_regs[port_rd_idx];
  assign exec_fire   = state == dsp_pkg::S_EXEC && !x_div_start;
  assign pc_fin      = (x_nx >= 32'(dsp_pkg::IMAGE_WORDS)) ?
                       PCW'(dsp_pkg::IMAGE_WORDS) : x_nx[PCW-1:0];

  // execute
  always_comb begin
    x_top = top; x_dp = dp; x_rp = rp; x_nx = pc32 + 32'd1;
    x_st = dsp_pkg::STAT_OK; x_cv = 1'b0; x_co = '0; x_wr = 1'b0;
    x_ds_we = 1'b0; x_ds_wa = dp_inc(dp); x_ds_wd = top;
    x_rs_we = 1'b0; x_rs_wd = top;
    x_img_we = 1'b0; x_div_start = 1'b0;
    x_pw_we = 1'b0; x_pw_data = '0;
    x_p0_clr = 1'b0; x_p0_set = 1'b0; x_p2_clr = 1'b0; x_p4_clr = 1'b0;
    x_p5_we = 1'b0; x_p5_val = '0;
    alu_op = dsp_pkg::ALU_ADD; alu_a = n_r; alu_b = top;
    if (op_r[31:5] != '0) begin
      x_st = dsp_pkg::STAT_ILLEGAL;
      x_nx = 32'(dsp_pkg::IMAGE_WORDS);
    end else begin
      unique case (dsp_pkg::op_t'(op_r[4:0]))
        dsp_pkg::OP_NOP: ;
        dsp_pkg::OP_LIT: begin
          x_dp = dp_inc(dp); x_ds_we = 1'b1; x_top = opnd; x_nx = pc32 + 32'd2;
        end
        dsp_pkg::OP_DUP: begin
          x_dp = dp_inc(dp); x_ds_we = 1'b1;
        end
        dsp_pkg::OP_DROP: begin
          x_top = n_r; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_SWAP: begin
          x_ds_we = 1'b1; x_ds_wa = dp; x_top = n_r;
        end
        dsp_pkg::OP_PUSH: begin
          x_rp = rp_inc(rp); x_rs_we = 1'b1; x_top = n_r; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_POP: begin
          x_dp = dp_inc(dp); x_ds_we = 1'b1; x_top = r_r; x_rp = rp_dec(rp);
        end
        dsp_pkg::OP_CALL: begin
          x_rp = rp_inc(rp); x_rs_we = 1'b1; x_rs_wd = pc32 + 32'd1; x_nx = opnd;
        end
        dsp_pkg::OP_JUMP: x_nx = opnd;
        dsp_pkg::OP_RETURN: begin
          x_nx = r_r + 32'd1; x_rp = rp_dec(rp);
        end
        dsp_pkg::OP_GT_JUMP: begin
          x_nx = alu_gt ? opnd : pc32 + 32'd2; x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_LT_JUMP: begin
          x_nx = alu_lt ? opnd : pc32 + 32'd2; x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_NE_JUMP: begin
          x_nx = !alu_eq ? opnd : pc32 + 32'd2; x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_EQ_JUMP: begin
          x_nx = alu_eq ? opnd : pc32 + 32'd2; x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_FETCH: x_top = opnd;
        dsp_pkg::OP_STORE: begin
          x_img_we = top < 32'(dsp_pkg::IMAGE_WORDS);
          x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_ADD: begin
          alu_op = dsp_pkg::ALU_ADD; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_SUB: begin
          alu_op = dsp_pkg::ALU_SUB; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_MUL: begin
          alu_op = dsp_pkg::ALU_MUL; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_DIVMOD: begin
          if (top == '0) begin
            x_st = dsp_pkg::STAT_DIV0; x_nx = 32'(dsp_pkg::IMAGE_WORDS);
          end else begin
            x_div_start = 1'b1;
          end
        end
        dsp_pkg::OP_AND: begin
          alu_op = dsp_pkg::ALU_AND; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_OR: begin
          alu_op = dsp_pkg::ALU_OR; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_XOR: begin
          alu_op = dsp_pkg::ALU_XOR; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_SHL: begin
          alu_op = dsp_pkg::ALU_SHL; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_SHR: begin
          alu_op = dsp_pkg::ALU_SHR; x_top = alu_y; x_dp = dp_dec(dp);
        end
        dsp_pkg::OP_ZERO_EXIT: begin
          if (top == '0) begin
            x_top = n_r; x_dp = dp_dec(dp); x_nx = r_r + 32'd1; x_rp = rp_dec(rp);
          end
        end
        dsp_pkg::OP_INC: begin
          alu_op = dsp_pkg::ALU_ADD; alu_a = top; alu_b = 32'd1; x_top = alu_y;
        end
        dsp_pkg::OP_DEC: begin
          alu_op = dsp_pkg::ALU_SUB; alu_a = top; alu_b = 32'd1; x_top = alu_y;
        end
        dsp_pkg::OP_IN: begin
          x_top = t_in_port ? port_rdata : '0; x_pw_we = t_in_port;
        end
        dsp_pkg::OP_OUT: begin
          x_p0_clr = 1'b1; x_pw_we = t_in_port; x_pw_data = n_r;
          x_top = ds_q; x_dp = dp_dec(dp_dec(dp));
        end
        dsp_pkg::OP_WAIT: begin
          if (port_regs[dsp_pkg::PORT_STATUS] != 32'd1) begin
            if (port_regs[dsp_pkg::PORT_STATUS] == '0 &&
                port_regs[dsp_pkg::PORT_KEY] == 32'd1) begin
              x_wr = 1'b1; x_nx = pc32;
            end else begin
              if (port_regs[dsp_pkg::PORT_CHAR] == 32'd1) begin
                x_cv = 1'b1; x_co = top; x_top = n_r; x_dp = dp_dec(dp);
                x_p2_clr = 1'b1; x_p0_set = 1'b1;
              end
              if (port_regs[dsp_pkg::PORT_SAVE] == 32'd1) begin
                x_p4_clr = 1'b1; x_p0_set = 1'b1;
              end
              priority if (port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_IMAGE_SIZE) begin
                x_p5_we = 1'b1; x_p5_val = 32'(dsp_pkg::IMAGE_WORDS); x_p0_set = 1'b1;
              end else if (port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_ZERO_A ||
                           port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_ZERO_B ||
                           port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_ZERO_C) begin
                x_p5_we = 1'b1; x_p5_val = '0; x_p0_set = 1'b1;
              end else if (port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_DATA_PTR) begin
                x_p5_we = 1'b1; x_p5_val = 32'(x_dp); x_p0_set = 1'b1;
              end else if (port_regs[dsp_pkg::PORT_QUERY] == dsp_pkg::QRY_RET_PTR) begin
                x_p5_we = 1'b1; x_p5_val = 32'(rp); x_p0_set = 1'b1;
              end else begin
                x_p5_we = 1'b0;
              end
            end
          end
        end
        default: begin
          x_st = dsp_pkg::STAT_ILLEGAL; x_nx = 32'(dsp_pkg::IMAGE_WORDS);
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dsp_pkg::S_CLEAR:
        if (clr_cnt == AW'(dsp_pkg::IMAGE_WORDS - 1)) state_next = dsp_pkg::S_IDLE;
      dsp_pkg::S_IDLE:
        if (req_valid && req_ready) state_next = dsp_pkg::S_CMD;
      dsp_pkg::S_CMD: begin
        if (cmd_r == dsp_pkg::CMD_STEP && !halted) state_next = dsp_pkg::S_DEC;
        else if (cmd_r == dsp_pkg::CMD_IMG_RD) state_next = dsp_pkg::S_RDW;
        else state_next = dsp_pkg::S_IDLE;
      end
      dsp_pkg::S_RDW: state_next = dsp_pkg::S_IDLE;
      dsp_pkg::S_DEC: state_next = dsp_pkg::S_EXEC;
      dsp_pkg::S_EXEC: state_next = x_div_start ? dsp_pkg::S_DIV : dsp_pkg::S_IDLE;
      dsp_pkg::S_DIV: if (div_done) state_next = dsp_pkg::S_IDLE;
      default: state_next = dsp_pkg::S_IDLE;
    endcase
  end

  // outputs: memory ports, ready, result
  always_comb begin
    req_ready = state == dsp_pkg::S_IDLE && !rsp_valid;

    img_ra = pc[AW-1:0];
    if (state == dsp_pkg::S_CMD && cmd_r == dsp_pkg::CMD_IMG_RD) img_ra = addr_r;
    else if (state == dsp_pkg::S_DEC)
      img_ra = (img_q == 32'(dsp_pkg::OP_FETCH)) ? top[AW-1:0] : pc[AW-1:0] + 1'b1;
    ds_ra = (state == dsp_pkg::S_DEC) ? dp_dec(dp) : dp;

    img_we = 1'b0; img_wa = clr_cnt; img_wd = '0;
    ds_we  = 1'b0; ds_wa  = clr_cnt[DW-1:0]; ds_wd = '0;
    rs_we  = 1'b0; rs_wa  = clr_cnt[RW-1:0]; rs_wd = '0;
    if (clearing) begin
      img_we = 1'b1;
      ds_we  = 32'(clr_cnt) < 32'(DATA_DEPTH);
      rs_we  = 32'(clr_cnt) < 32'(RETURN_DEPTH);
    end else if (state == dsp_pkg::S_CMD) begin
      img_we = cmd_r == dsp_pkg::CMD_IMG_WR; img_wa = addr_r; img_wd = data_r;
    end else if (exec_fire) begin
      img_we = x_img_we; img_wa = top[AW-1:0]; img_wd = n_r;
      ds_we = x_ds_we; ds_wa = x_ds_wa; ds_wd = x_ds_wd;
      rs_we = x_rs_we; rs_wa = rp_inc(rp); rs_wd = x_rs_wd;
    end else if (state == dsp_pkg::S_DIV) begin
      ds_we = div_done; ds_wa = dp; ds_wd = div_rem;
    end

    fin = 1'b0;
    rsp_d.pc = pc; rsp_d.top = top; rsp_d.read_data = '0;
    rsp_d.char_valid = 1'b0; rsp_d.char_out = '0; rsp_d.wait_request = 1'b0;
    rsp_d.status = dsp_pkg::STAT_OK;
    unique case (state)
      dsp_pkg::S_CMD: begin
        fin = !((cmd_r == dsp_pkg::CMD_STEP && !halted) || cmd_r == dsp_pkg::CMD_IMG_RD);
        if (cmd_r == dsp_pkg::CMD_STEP) rsp_d.status = dsp_pkg::STAT_HALT;
        if (cmd_r == dsp_pkg::CMD_PORT_RD && 32'(addr_r) < 32'(PORT_COUNT))
          rsp_d.read_data = port_rdata;
      end
      dsp_pkg::S_RDW: begin
        fin = 1'b1; rsp_d.read_data = img_q;
      end
      dsp_pkg::S_EXEC: begin
        fin = !x_div_start;
        rsp_d.pc = pc_fin; rsp_d.top = x_top; rsp_d.char_valid = x_cv;
        rsp_d.char_out = x_co; rsp_d.wait_request = x_wr; rsp_d.status = x_st;
      end
      dsp_pkg::S_DIV: begin
        fin = div_done; rsp_d.pc = pc + 1'b1; rsp_d.top = div_quot;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_wa] <= img_wd;
    img_q <= img_mem[img_ra];
  end

  always_ff @(posedge clk) begin
    if (ds_we) ds_mem[ds_wa] <= ds_wd;
    ds_q <= ds_mem[ds_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_q <= rs_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) port_regs[i] <= '0;
    end else begin
      if (state == dsp_pkg::S_CMD && cmd_r == dsp_pkg::CMD_PORT_WR &&
          32'(addr_r) < 32'(PORT_COUNT))
        port_regs[addr_r[PW-1:0]] <= data_r;
      if (exec_fire) begin
        if (x_p0_clr) port_regs[dsp_pkg::PORT_STATUS] <= '0;
        if (x_p0_set) port_regs[dsp_pkg::PORT_STATUS] <= 32'd1;
        if (x_p2_clr) port_regs[dsp_pkg::PORT_CHAR] <= '0;
        if (x_p4_clr) port_regs[dsp_pkg::PORT_SAVE] <= '0;
        if (x_p5_we) port_regs[dsp_pkg::PORT_QUERY] <= x_p5_val;
        if (x_pw_we) port_regs[top[PW-1:0]] <= x_pw_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsp_pkg::S_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      top       <= '0;
      dp        <= '0;
      rp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (fin) rsp_valid <= 1'b1;
      if (exec_fire) begin
        pc  <= pc_fin;
        top <= x_top;
        dp  <= x_dp;
        rp  <= x_rp;
      end
      if (state == dsp_pkg::S_DIV && div_done) begin
        pc  <= pc + 1'b1;
        top <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd_r  <= dsp_pkg::cmd_t'(req.command);
      addr_r <= req.address;
      data_r <= req.data;
    end
    if (state == dsp_pkg::S_DEC) begin
      op_r     <= img_q;
      n_r      <= ds_q;
      r_r      <= rs_q;
      opnd_oob <= (img_q == 32'(dsp_pkg::OP_FETCH)) ?
                  (top >= 32'(dsp_pkg::IMAGE_WORDS)) :
                  (pc32 + 32'd1 >= 32'(dsp_pkg::IMAGE_WORDS));
    end
    if (fin) rsp <= rsp_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dsp_checker.sv =====
//------------------------------------------------------------------------------
// dsp_checker
// Port-level checks for the dual-stack processor core, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module dsp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input dsp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input dsp_pkg::rsp_t rsp
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready high right after a request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == dsp_pkg::STAT_ILLEGAL ||
                   rsp.status == dsp_pkg::STAT_DIV0 ||
                   rsp.status == dsp_pkg::STAT_HALT))
      |-> rsp.pc == dsp_pkg::PC_W'(dsp_pkg::IMAGE_WORDS))
    else $error("fault status without halted pc");

  a_wait_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.wait_request) |-> (!rsp.char_valid && rsp.status == dsp_pkg::STAT_OK))
    else $error("wait request mixed with char output or fault");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");

endmodule

bind dual_stack_processor_core dsp_checker u_dsp_checker (.*);

`default_nettype wire
